@@ src/bdc_pkg.sv @@
// ----------------------------------------------------------------------------
// bdc_pkg
// Shared types and constants for the button repeat and double-click block.
// ----------------------------------------------------------------------------
`default_nettype none

package bdc_pkg;

    localparam int NUM_BUTTONS_DEF = 3;
    localparam int MAX_BUTTONS     = 8;
    localparam int BUTTON_W        = 3;
    localparam int CFG_W           = 8;
    localparam int CFG_IDX_W       = 2;
    localparam int COUNT_W         = 10;
    localparam int IN_TDATA_W      = 8;
    localparam int OUT_TDATA_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_HELD_DELAY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HELD_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW = 2'd2;

    localparam logic [CFG_W-1:0] HELD_DELAY_RST    = 8'd40;
    localparam logic [CFG_W-1:0] HELD_INTERVAL_RST = 8'd5;
    localparam logic [CFG_W-1:0] DOUBLE_WINDOW_RST = 8'd15;

    localparam logic signed [COUNT_W-1:0] COUNT_FLOOR = -10'sd256;
    localparam logic signed [COUNT_W-1:0] COUNT_CEIL  = 10'sd511;

    typedef struct packed {
        logic [CFG_W-1:0] delay;
        logic [CFG_W-1:0] interval;
        logic [CFG_W-1:0] window;
    } bdc_cfg_t;

    typedef struct packed {
        logic dbl;
        logic held;
        logic released;
        logic pressed;
        logic down;
    } bdc_flags_t;

    typedef struct packed {
        logic [BUTTON_W-1:0] double_buttons;
        logic [BUTTON_W-1:0] held_buttons;
        logic [BUTTON_W-1:0] released_buttons;
        logic [BUTTON_W-1:0] pressed_buttons;
        logic [BUTTON_W-1:0] down_buttons;
    } bdc_result_t;

endpackage

`default_nettype wire

@@ src/bdc_lane.sv @@
// ----------------------------------------------------------------------------
// bdc_lane
// Per-button core: edge detect, frame counter, repeat phase and flags.
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_lane
    import bdc_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         en,
    input  wire         level,
    input  bdc_cfg_t    cfg,
    output bdc_flags_t  flags
);

    logic                       level_reg;
    logic signed [COUNT_W-1:0]  count_reg;
    logic signed [COUNT_W-1:0]  count_next;
    logic [CFG_W-1:0]           phase_reg;
    logic [CFG_W-1:0]           phase_next;
    logic [CFG_W-1:0]           phase_inc;
    logic [CFG_W-1:0]           interval_eff;
    logic signed [COUNT_W-1:0]  delay_s;
    logic signed [COUNT_W-1:0]  window_neg;
    logic                       pressed;
    logic                       released;
    logic                       held;
    logic                       dbl;

    assign pressed      = level & ~level_reg;
    assign released     = ~level & level_reg;
    assign interval_eff = (cfg.interval == '0) ? CFG_W'(1) : cfg.interval;
    assign delay_s      = $signed({{(COUNT_W-CFG_W){1'b0}}, cfg.delay});
    assign window_neg   = -$signed({{(COUNT_W-CFG_W){1'b0}}, cfg.window});
    assign dbl          = pressed && (count_reg >= window_neg);

    always_comb
    begin
        count_next = count_reg;
        phase_next = phase_reg;
        held       = 1'b0;
        phase_inc  = '0;
        if (pressed)
        begin
            count_next = '0;
            phase_next = '0;
        end
        else if (level)
        begin
            if (count_reg < COUNT_CEIL)
            begin
                count_next = count_reg + 10'sd1;
            end
        end
        else if (released)
        begin
            count_next = '0;
        end
        else if (count_reg > COUNT_FLOOR)
        begin
            count_next = count_reg - 10'sd1;
        end

        if (level)
        begin
            if (count_next == delay_s)
            begin
                held       = 1'b1;
                phase_next = '0;
            end
            else if (count_next > delay_s)
            begin
                phase_inc = phase_next + CFG_W'(1);
                if (phase_inc >= interval_eff)
                begin
                    held       = 1'b1;
                    phase_next = '0;
                end
                else
                begin
                    phase_next = phase_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 1'b0;
            count_reg <= COUNT_FLOOR;
            phase_reg <= '0;
        end
        else if (en)
        begin
            level_reg <= level;
            count_reg <= count_next;
            phase_reg <= phase_next;
        end
    end

    assign flags.down     = level;
    assign flags.pressed  = pressed;
    assign flags.released = released;
    assign flags.held     = held;
    assign flags.dbl      = dbl;

endmodule

`default_nettype wire

@@ src/bdc_merge.sv @@
// ----------------------------------------------------------------------------
// bdc_merge
// Gathers lane flags into one result beat and buffers it in a two-entry
// output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_merge
    import bdc_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     push,
    input  bdc_flags_t              lane_flags [NUM_BUTTONS],
    output logic                    ready,
    output logic                    m_tvalid,
    input  wire                     m_tready,
    // down[2:0], pressed[5:3], released[8:6], held[11:9], double[14:12], zero
    output logic [OUT_TDATA_W-1:0]  m_tdata
);

    bdc_result_t  result;
    bdc_result_t  main_reg;
    bdc_result_t  skid_reg;
    logic         main_valid_reg;
    logic         skid_valid_reg;
    logic         pop;

    always_comb
    begin
        result = '0;
        for (int i = 0; i < BUTTON_W; i++)
        begin
            if (i < NUM_BUTTONS)
            begin
                result.down_buttons[i]     = lane_flags[i].down;
                result.pressed_buttons[i]  = lane_flags[i].pressed;
                result.released_buttons[i] = lane_flags[i].released;
                result.held_buttons[i]     = lane_flags[i].held;
                result.double_buttons[i]   = lane_flags[i].dbl;
            end
        end
    end

    assign pop   = main_valid_reg && m_tready;
    assign ready = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (!main_valid_reg)
        begin
            main_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            main_reg <= skid_valid_reg ? skid_reg : result;
        end
        else if (!main_valid_reg)
        begin
            main_reg <= result;
        end
        else if (push)
        begin
            skid_reg <= result;
        end
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - $bits(bdc_result_t)){1'b0}}, main_reg};

    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held without main entry");

    a_held_only_down: assert property (@(posedge clk) disable iff (!rst_n)
        main_valid_reg |-> ((main_reg.held_buttons & ~main_reg.down_buttons) == '0))
        else $error("held reported for a button that is up");

    a_double_on_press: assert property (@(posedge clk) disable iff (!rst_n)
        main_valid_reg |-> ((main_reg.double_buttons & ~main_reg.pressed_buttons) == '0))
        else $error("double click reported without a press");

    a_edges_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        main_valid_reg |-> ((main_reg.pressed_buttons & main_reg.released_buttons) == '0))
        else $error("press and release on the same button in one beat");

endmodule

`default_nettype wire

@@ src/button_repeat_and_double_click.sv @@
// ----------------------------------------------------------------------------
// button_repeat_and_double_click
// Per-button down, edge, typematic held and double-click reporting.
// ----------------------------------------------------------------------------
// Each input beat is one frame of sampled button levels and yields exactly one
// result beat. One lane per button updates its frame counter and repeat phase
// in the accept cycle, so a new frame is taken every clock while s_tready is
// high; each result is registered in the output buffer. A two-entry output
// buffer keeps s_tready high while one result waits, dropping it only when
// both entries are full. Write the configuration registers only while no
// frame is in flight; counters start at the idle floor after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module button_repeat_and_double_click
    import bdc_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]     cfg_index,
    input  wire [CFG_W-1:0]         cfg_data,
    input  wire                     s_tvalid,
    output logic                    s_tready,
    // button_levels[2:0], zero
    input  wire [IN_TDATA_W-1:0]    s_tdata,
    output logic                    m_tvalid,
    input  wire                     m_tready,
    // down[2:0], pressed[5:3], released[8:6], held[11:9], double[14:12], zero
    output logic [OUT_TDATA_W-1:0]  m_tdata
);

    bdc_cfg_t    cfg_reg;
    bdc_flags_t  lane_flags [NUM_BUTTONS];
    logic        accept;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delay    <= HELD_DELAY_RST;
            cfg_reg.interval <= HELD_INTERVAL_RST;
            cfg_reg.window   <= DOUBLE_WINDOW_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_HELD_DELAY:    cfg_reg.delay    <= cfg_data;
                REG_HELD_INTERVAL: cfg_reg.interval <= cfg_data;
                REG_DOUBLE_WINDOW: cfg_reg.window   <= cfg_data;
                default:           ;
            endcase
        end
    end

    for (genvar i = 0; i < NUM_BUTTONS; i++)
    begin : g_lane
        logic level;
        if (i < BUTTON_W)
        begin : g_used
            assign level = s_tdata[i];
        end
        else
        begin : g_unused
            assign level = 1'b0;
        end

        bdc_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (accept),
            .level (level),
            .cfg   (cfg_reg),
            .flags (lane_flags[i])
        );
    end

    bdc_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .lane_flags (lane_flags),
        .ready      (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire
